>>> rtl/protected_memory_map_with_rom_upload_unit_macros.svh
// Assertion macros shared by the checker of the protected memory map.
// No dependencies; include by bare file name.
`ifndef PROTECTED_MEMORY_MAP_WITH_ROM_UPLOAD_UNIT_MACROS_SVH
`define PROTECTED_MEMORY_MAP_WITH_ROM_UPLOAD_UNIT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define PMM_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every rising clock edge, reset included.
`define PMM_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/pmm_pkg.sv
// Shared types and constants of the protected memory map with ROM upload.
// No dependencies; used by the interfaces and all modules.
`default_nettype none

package pmm_pkg;

   localparam int ADDR_W       = 16;
   localparam int DATA_W       = 8;
   localparam int OPCODE_W     = 3;
   localparam int COUNT_W      = 16;
   localparam int CHECK_W      = 32;
   localparam int CHECK_ROT    = 5;
   localparam int SCREEN_BITS  = 14;
   localparam int MEMORY_DEPTH = 65536;
   localparam int ROM_BYTES    = 16384;

   localparam logic [ADDR_W-1:0]  ROM_LIMIT = ADDR_W'(ROM_BYTES);
   localparam logic [ADDR_W-1:0]  UPPER_RAM = 16'h8000;
   localparam logic [ADDR_W-1:0]  ADDR_LAST = ADDR_W'(MEMORY_DEPTH - 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [DATA_W-1:0]  FILL_ONES = '1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_CPU_READ    = 3'd0,
      OP_CPU_WRITE   = 3'd1,
      OP_DBG_READ    = 3'd2,
      OP_DBG_WRITE   = 3'd3,
      OP_SCREEN_READ = 3'd4,
      OP_ROM_UPLOAD  = 3'd5,
      OP_CLEAR       = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_CLEAR,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic capture;     // latch the request beat
      logic access;      // drive the memory port for the held request
      logic clear_step;  // write one RAM byte of the clear sweep
      logic commit;      // update state and load the response register
   } cmd_type;

   typedef struct packed {
      logic op_clear;
      logic clear_last;
   } status_type;

endpackage

`default_nettype wire

>>> rtl/pmm_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on pmm_pkg for field widths.
`default_nettype none

interface pmm_req_if;
   logic                          valid;
   logic                          ready;
   logic [pmm_pkg::OPCODE_W-1:0]  opcode;
   logic [pmm_pkg::ADDR_W-1:0]    address;
   logic [pmm_pkg::DATA_W-1:0]    data;

   modport source (output valid, opcode, address, data, input ready);
   modport sink   (input valid, opcode, address, data, output ready);
endinterface

interface pmm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pmm_pkg::DATA_W-1:0]    read_data;
   logic                          event_seen;
   logic [pmm_pkg::ADDR_W-1:0]    last_access_address;
   logic [pmm_pkg::DATA_W-1:0]    last_access_value;
   logic                          last_access_write;
   logic [pmm_pkg::COUNT_W-1:0]   upload_count;
   logic [pmm_pkg::CHECK_W-1:0]   upload_checksum;

   modport source (output valid, read_data, event_seen, last_access_address,
                   last_access_value, last_access_write, upload_count,
                   upload_checksum, input ready);
   modport sink   (input valid, read_data, event_seen, last_access_address,
                   last_access_value, last_access_write, upload_count,
                   upload_checksum, output ready);
endinterface

`default_nettype wire

>>> rtl/pmm_ctrl.sv
// Control state machine: request accept, memory access, clear sweep, response.
// Depends on pmm_pkg for state, command and status types.
`default_nettype none

module pmm_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output pmm_pkg::cmd_type      cmd,
   input  pmm_pkg::status_type   status
);
   import pmm_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            cmd.access = 1'b1;
            state_in   = status.op_clear ? ST_CLEAR : ST_RESULT;
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            // hold until the response register is free or draining
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> rtl/pmm_datapath.sv
// Datapath: 64K byte store, request hold, access record, upload count and
// checksum, response register. Depends on pmm_pkg.
`default_nettype none

module pmm_datapath (
   input  wire                              clock,
   input  wire                              reset,
   input  pmm_pkg::cmd_type                 cmd,
   output pmm_pkg::status_type              status,
   input  wire [pmm_pkg::OPCODE_W-1:0]      req_opcode,
   input  wire [pmm_pkg::ADDR_W-1:0]        req_address,
   input  wire [pmm_pkg::DATA_W-1:0]        req_data,
   input  wire                              csr_wr_en,
   input  wire                              csr_wr_data,
   output logic [pmm_pkg::DATA_W-1:0]       rsp_read_data,
   output logic                             rsp_event_seen,
   output logic [pmm_pkg::ADDR_W-1:0]       rsp_last_access_address,
   output logic [pmm_pkg::DATA_W-1:0]       rsp_last_access_value,
   output logic                             rsp_last_access_write,
   output logic [pmm_pkg::COUNT_W-1:0]      rsp_upload_count,
   output logic [pmm_pkg::CHECK_W-1:0]      rsp_upload_checksum
);
   import pmm_pkg::*;

   // held request
   op_type              op_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [DATA_W-1:0]   data_ff;

   logic                model_16k_ff;

   logic [DATA_W-1:0]   mem [MEMORY_DEPTH];
   logic [DATA_W-1:0]   rd_ff;
   logic                mem_we, mem_re;
   logic [ADDR_W-1:0]   mem_wa, mem_ra;
   logic [DATA_W-1:0]   mem_wd;

   logic [ADDR_W-1:0]   clr_addr_ff;

   logic [ADDR_W-1:0]   last_addr_ff, last_addr_in;
   logic [DATA_W-1:0]   last_value_ff, last_value_in;
   logic                last_write_ff, last_write_in;
   logic                event_ff, event_in;
   logic [COUNT_W-1:0]  count_ff, count_in, base_count;
   logic [CHECK_W-1:0]  check_ff, check_in, base_check;
   logic [DATA_W-1:0]   read_data_in;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= op_type'(req_opcode);
         addr_ff <= req_address;
         data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         model_16k_ff <= 1'b0;
      end else if (csr_wr_en) begin
         model_16k_ff <= csr_wr_data;
      end
   end

   // memory port: one write, one registered read
   always_comb begin
      mem_we = 1'b0;
      mem_re = 1'b0;
      mem_wa = addr_ff;
      mem_ra = addr_ff;
      mem_wd = data_ff;
      if (cmd.access) begin
         unique case (op_ff)
            OP_CPU_READ, OP_DBG_READ: mem_re = 1'b1;
            OP_SCREEN_READ: begin
               mem_re = 1'b1;
               mem_ra = ROM_LIMIT + ADDR_W'(addr_ff[SCREEN_BITS-1:0]);
            end
            OP_CPU_WRITE, OP_DBG_WRITE: mem_we = (addr_ff >= ROM_LIMIT);
            OP_ROM_UPLOAD:              mem_we = (addr_ff < ROM_LIMIT);
            default: ;
         endcase
      end
      if (cmd.clear_step) begin
         mem_we = 1'b1;
         mem_wa = clr_addr_ff;
         mem_wd = (model_16k_ff && clr_addr_ff >= UPPER_RAM) ? FILL_ONES : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_ra];
      end
   end

   // clear sweep pointer: start at the first RAM byte, advance each step
   always_ff @(posedge clock) begin
      if (cmd.access) begin
         clr_addr_ff <= ROM_LIMIT;
      end else if (cmd.clear_step) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
      end
   end

   assign status.op_clear   = (op_ff == OP_CLEAR);
   assign status.clear_last = (clr_addr_ff == ADDR_LAST);

   // upload at offset zero restarts count and checksum
   assign base_count = (addr_ff == '0) ? '0 : count_ff;
   assign base_check = (addr_ff == '0) ? '0 : check_ff;

   always_comb begin
      last_addr_in  = last_addr_ff;
      last_value_in = last_value_ff;
      last_write_in = last_write_ff;
      event_in      = event_ff;
      count_in      = count_ff;
      check_in      = check_ff;
      read_data_in  = '0;
      case (op_ff)
         OP_CPU_READ: begin
            read_data_in  = rd_ff;
            last_addr_in  = addr_ff;
            last_value_in = rd_ff;
            last_write_in = 1'b0;
            event_in      = 1'b1;
         end
         OP_CPU_WRITE: begin
            last_addr_in  = addr_ff;
            last_value_in = data_ff;
            last_write_in = 1'b1;
            event_in      = 1'b1;
         end
         OP_DBG_READ, OP_SCREEN_READ: read_data_in = rd_ff;
         OP_ROM_UPLOAD: begin
            if (addr_ff < ROM_LIMIT) begin
               count_in = (base_count == COUNT_MAX) ? base_count
                                                    : base_count + COUNT_W'(1);
               check_in = {base_check[CHECK_W-CHECK_ROT-1:0],
                           base_check[CHECK_W-1:CHECK_W-CHECK_ROT]}
                        ^ (CHECK_W'(data_ff) + CHECK_W'(addr_ff));
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_addr_ff  <= '0;
         last_value_ff <= '0;
         last_write_ff <= 1'b0;
         event_ff      <= 1'b0;
         count_ff      <= '0;
         check_ff      <= '0;
      end else if (cmd.commit) begin
         last_addr_ff  <= last_addr_in;
         last_value_ff <= last_value_in;
         last_write_ff <= last_write_in;
         event_ff      <= event_in;
         count_ff      <= count_in;
         check_ff      <= check_in;
      end
   end

   // response register holds the beat while the sink stalls
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_read_data           <= read_data_in;
         rsp_event_seen          <= event_in;
         rsp_last_access_address <= last_addr_in;
         rsp_last_access_value   <= last_value_in;
         rsp_last_access_write   <= last_write_in;
         rsp_upload_count        <= count_in;
         rsp_upload_checksum     <= check_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/protected_memory_map_with_rom_upload_unit.sv
// Top level of the protected 64K memory map with ROM upload.
// Depends on pmm_pkg, pmm_if, pmm_ctrl and pmm_datapath.
//
//   channel   direction  handshake         carries
//   req_ch    in         valid / ready     opcode, address, data
//   rsp_ch    out        valid / ready     read data, access record, upload
//   csr       in         csr_wr_en only    model_16k
//
// Each request passes through accept, memory port access and response load.
// Clear RAM adds a sweep over the 49152 RAM bytes, one byte per cycle through the
// single write port of the byte store.
// Reset is synchronous; the byte store is not cleared by it.
// A stalled response holds in its register; the next request is taken
// once the prior one has been loaded there.
`default_nettype none

module protected_memory_map_with_rom_upload_unit (
   input  wire       clock,
   input  wire       reset,
   pmm_req_if.sink   req_ch,
   pmm_rsp_if.source rsp_ch,
   input  wire       csr_wr_en,
   input  wire       csr_wr_data
);
   import pmm_pkg::*;

   cmd_type    cmd;
   status_type status;

   pmm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   pmm_datapath u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .status                  (status),
      .req_opcode              (req_ch.opcode),
      .req_address             (req_ch.address),
      .req_data                (req_ch.data),
      .csr_wr_en               (csr_wr_en),
      .csr_wr_data             (csr_wr_data),
      .rsp_read_data           (rsp_ch.read_data),
      .rsp_event_seen          (rsp_ch.event_seen),
      .rsp_last_access_address (rsp_ch.last_access_address),
      .rsp_last_access_value   (rsp_ch.last_access_value),
      .rsp_last_access_write   (rsp_ch.last_access_write),
      .rsp_upload_count        (rsp_ch.upload_count),
      .rsp_upload_checksum     (rsp_ch.upload_checksum)
   );

endmodule

`default_nettype wire

>>> rtl/pmm_checker.sv
// Port-level checker for the protected memory map, bound to the top level.
// Depends on pmm_pkg and the assertion macro header.
`default_nettype none

`include "protected_memory_map_with_rom_upload_unit_macros.svh"

module pmm_checker (
   input wire                             clock,
   input wire                             reset,
   input wire                             req_valid,
   input wire                             req_ready,
   input wire                             rsp_valid,
   input wire                             rsp_ready,
   input wire                             rsp_event_seen,
   input wire [pmm_pkg::COUNT_W-1:0]      rsp_upload_count,
   input wire [pmm_pkg::CHECK_W-1:0]      rsp_upload_checksum
);
   import pmm_pkg::*;

   logic [1:0] open_ff, open_in;
   logic       seen_ff, seen_in;
   logic       req_beat, rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   // requests taken but not yet answered
   always_comb begin
      open_in = open_ff;
      if (req_beat && !rsp_beat) begin
         open_in = open_ff + 2'd1;
      end else if (rsp_beat && !req_beat) begin
         open_in = open_ff - 2'd1;
      end
   end

   assign seen_in = seen_ff || (rsp_beat && rsp_event_seen);

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
         seen_ff <= 1'b0;
      end else begin
         open_ff <= open_in;
         seen_ff <= seen_in;
      end
   end

   `PMM_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")
   `PMM_ASSERT(a_no_invented, clock, reset, rsp_valid |-> open_ff != 2'd0, "response without a request")
   `PMM_ASSERT(a_open_bound, clock, reset, open_ff != 2'd3, "more than two requests outstanding")
   `PMM_ASSERT(a_event_sticky, clock, reset, rsp_valid && seen_ff |-> rsp_event_seen, "event flag fell")
   `PMM_ASSERT(a_count_check, clock, reset, rsp_valid && rsp_upload_count == '0 |-> rsp_upload_checksum == '0, "checksum without upload")

endmodule

bind protected_memory_map_with_rom_upload_unit pmm_checker u_pmm_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_ch.valid),
   .req_ready           (req_ch.ready),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_event_seen      (rsp_ch.event_seen),
   .rsp_upload_count    (rsp_ch.upload_count),
   .rsp_upload_checksum (rsp_ch.upload_checksum)
);

`default_nettype wire

>>> tb/memory_map_checker.sv
`timescale 1ns / 1ps
// Checker for the protected memory map: watches the request, response and CSR
// ports, predicts every response beat and compares it field by field.
// Depends on pmm_pkg and the channel interfaces in pmm_if.

module memory_map_checker (
   input  logic clock,
   input  logic reset,
   pmm_req_if   req_mon,
   pmm_rsp_if   rsp_mon,
   input  logic csr_wr_en,
   input  logic csr_wr_data,
   output int   fail_count,
   output int   reply_backlog
);
   import pmm_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0]  read_data;
      logic               event_seen;
      logic [ADDR_W-1:0]  last_addr;
      logic [DATA_W-1:0]  last_value;
      logic               last_write;
      logic [COUNT_W-1:0] count;
      logic [CHECK_W-1:0] checksum;
   } map_status_type;

   logic [DATA_W-1:0]  byte_image [MEMORY_DEPTH];
   logic [ADDR_W-1:0]  cpu_addr_q;
   logic [DATA_W-1:0]  cpu_value_q;
   logic               cpu_write_q;
   logic               cpu_seen_q;
   logic [COUNT_W-1:0] upload_count_q;
   logic [CHECK_W-1:0] upload_sum_q;
   logic               fill_16k;

   map_status_type status_due [$];

   task automatic apply_operation(input logic [OPCODE_W-1:0] code,
                                  input logic [ADDR_W-1:0] addr,
                                  input logic [DATA_W-1:0] wdata,
                                  output map_status_type snap);
      logic [DATA_W-1:0] rd;
      rd = '0;
      case (code)
         OP_CPU_READ: begin
            rd          = byte_image[addr];
            cpu_addr_q  = addr;
            cpu_value_q = rd;
            cpu_write_q = 1'b0;
            cpu_seen_q  = 1'b1;
         end
         OP_CPU_WRITE: begin
            cpu_addr_q  = addr;
            cpu_value_q = wdata;
            cpu_write_q = 1'b1;
            cpu_seen_q  = 1'b1;
            if (addr >= ROM_LIMIT) byte_image[addr] = wdata;
         end
         OP_DBG_READ: rd = byte_image[addr];
         OP_DBG_WRITE: begin
            if (addr >= ROM_LIMIT) byte_image[addr] = wdata;
         end
         OP_SCREEN_READ: rd = byte_image[ROM_LIMIT + {2'b00, addr[SCREEN_BITS-1:0]}];
         OP_ROM_UPLOAD: begin
            if (addr < ROM_LIMIT) begin
               byte_image[addr] = wdata;
               // offset zero restarts the count and the checksum
               if (addr == '0) begin
                  upload_count_q = '0;
                  upload_sum_q   = '0;
               end
               if (upload_count_q != COUNT_MAX) upload_count_q++;
               upload_sum_q = {upload_sum_q[CHECK_W-CHECK_ROT-1:0],
                               upload_sum_q[CHECK_W-1:CHECK_W-CHECK_ROT]}
                              ^ (CHECK_W'(wdata) + CHECK_W'(addr));
            end
         end
         OP_CLEAR: begin
            for (int i = ROM_BYTES; i < MEMORY_DEPTH; i++)
               byte_image[i] = (fill_16k && i >= int'(UPPER_RAM)) ? FILL_ONES : '0;
         end
         default: ;
      endcase
      snap.read_data  = rd;
      snap.event_seen = cpu_seen_q;
      snap.last_addr  = cpu_addr_q;
      snap.last_value = cpu_value_q;
      snap.last_write = cpu_write_q;
      snap.count      = upload_count_q;
      snap.checksum   = upload_sum_q;
   endtask

   task automatic check_field(input string field, input logic [CHECK_W-1:0] want,
                              input logic [CHECK_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      map_status_type want;
      if (reset) begin
         cpu_addr_q     = '0;
         cpu_value_q    = '0;
         cpu_write_q    = 1'b0;
         cpu_seen_q     = 1'b0;
         upload_count_q = '0;
         upload_sum_q   = '0;
         fill_16k       = 1'b0;
         fail_count     = 0;
         status_due.delete();
      end else begin
         // retire the response beat first so a fresh request cannot mask a stray one
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (status_due.size() == 0) begin
               $error("response beat with no request outstanding");
               fail_count++;
            end else begin
               want = status_due.pop_front();
               check_field("read_data", CHECK_W'(want.read_data), CHECK_W'(rsp_mon.read_data));
               check_field("event_seen", CHECK_W'(want.event_seen),
                           CHECK_W'(rsp_mon.event_seen));
               check_field("last_access_address", CHECK_W'(want.last_addr),
                           CHECK_W'(rsp_mon.last_access_address));
               check_field("last_access_value", CHECK_W'(want.last_value),
                           CHECK_W'(rsp_mon.last_access_value));
               check_field("last_access_write", CHECK_W'(want.last_write),
                           CHECK_W'(rsp_mon.last_access_write));
               check_field("upload_count", CHECK_W'(want.count),
                           CHECK_W'(rsp_mon.upload_count));
               check_field("upload_checksum", want.checksum, rsp_mon.upload_checksum);
            end
         end
         if (csr_wr_en) fill_16k = csr_wr_data;
         if (req_mon.valid && req_mon.ready) begin
            apply_operation(req_mon.opcode, req_mon.address, req_mon.data, want);
            status_due.push_back(want);
         end
      end
      reply_backlog = status_due.size();
   end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Top of the memory map testbench: clock, reset, request and CSR stimulus,
// response back-pressure, watchdog and verdict.
// Depends on pmm_pkg, pmm_if, the block and memory_map_checker.

module testbench;
   import pmm_pkg::*;

   localparam int RESET_CYCLES   = 12;
   localparam int SETTLE_CYCLES  = 8;
   localparam int QUIET_LIMIT    = 200000;
   localparam int SQUEEZE_CYCLES = 150;
   localparam int ROM_SEED_BITS  = 6;
   localparam int PHASE_BEATS    = 400;
   localparam int PHASES         = 4;

   // opcode outside the defined set; the block must leave all state alone
   localparam logic [OPCODE_W-1:0] OP_SPARE = 3'd7;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;
   int   fail_count;
   int   reply_backlog;
   int   useful_beats;
   int   hold_left;
   int   quiet_cycles;
   bit   idle_on;
   bit   squeeze_ask;
   bit   rom_loaded [ROM_BYTES];

   pmm_req_if req_ch ();
   pmm_rsp_if rsp_ch ();

   protected_memory_map_with_rom_upload_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   memory_map_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .reply_backlog (reply_backlog)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic [ADDR_W-1:0] pick_address();
      logic [ADDR_W-1:0] a;
      a = ADDR_W'($urandom);
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 5))
            0:       a = '0;
            1:       a = ROM_LIMIT - 1;
            2:       a = ROM_LIMIT;
            3:       a = UPPER_RAM - 1;
            4:       a = UPPER_RAM;
            default: a = ADDR_LAST;
         endcase
      end
      return a;
   endfunction

   // Present one request beat and hold it until accepted; valid stays high
   // for a back-to-back beat and drops only for an idle burst.
   task automatic push_beat(input logic [OPCODE_W-1:0] op, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
      // a ROM byte never uploaded holds nothing defined; read a seeded one instead
      if ((op == OP_CPU_READ || op == OP_DBG_READ) && addr < ROM_LIMIT
          && !rom_loaded[addr[SCREEN_BITS-1:0]])
         addr = ADDR_W'(addr[ROM_SEED_BITS-1:0]);
      if (op == OP_ROM_UPLOAD && addr < ROM_LIMIT)
         rom_loaded[addr[SCREEN_BITS-1:0]] = 1'b1;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.opcode  <= op;
      req_ch.address <= addr;
      req_ch.data    <= data;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (!(op == OP_SPARE || (op == OP_ROM_UPLOAD && addr >= ROM_LIMIT)
            || (op == OP_DBG_WRITE && addr < ROM_LIMIT)))
         useful_beats++;
   endtask

   // Drop valid and wait until every response is back and the block is idle.
   task automatic quiesce();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (reply_backlog != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_fill_mode(input logic mode);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   // response back-pressure: short random stalls plus the occasional long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= 0;
      end else if (squeeze_ask) begin
         squeeze_ask = 1'b0;
         rsp_ch.ready <= 1'b0;
         hold_left    <= SQUEEZE_CYCLES - 1;
      end else if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= $urandom_range(0, 4);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int                clear_at;
      int                len;
      logic              cleared;
      logic              squeezed;
      logic [ADDR_W-1:0] a;
      logic [OPCODE_W-1:0] op;

      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = 1'b0;
      req_ch.valid   = 1'b0;
      req_ch.opcode  = '0;
      req_ch.address = '0;
      req_ch.data    = '0;
      rsp_ch.ready   = 1'b0;
      idle_on        = 1'b1;
      squeeze_ask    = 1'b0;
      useful_beats   = 0;
      quiet_cycles   = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: fill RAM first so every later read hits a written byte.
      set_fill_mode(1'b1);
      push_beat(OP_CLEAR,       ADDR_LAST,     FILL_ONES);
      push_beat(OP_CPU_READ,    ROM_LIMIT,     8'h00);
      push_beat(OP_CPU_READ,    UPPER_RAM - 1, 8'h00);
      push_beat(OP_DBG_READ,    UPPER_RAM,     8'h00);
      push_beat(OP_CPU_READ,    ADDR_LAST,     8'h00);
      push_beat(OP_ROM_UPLOAD,  16'h0000,      FILL_ONES);
      push_beat(OP_ROM_UPLOAD,  ROM_LIMIT - 1, 8'h00);
      push_beat(OP_ROM_UPLOAD,  ROM_LIMIT,     8'h5a);
      push_beat(OP_ROM_UPLOAD,  ADDR_LAST,     FILL_ONES);
      push_beat(OP_CPU_READ,    16'h0000,      8'h00);
      push_beat(OP_CPU_WRITE,   16'h0000,      8'h12);
      push_beat(OP_CPU_WRITE,   ROM_LIMIT - 1, FILL_ONES);
      push_beat(OP_DBG_WRITE,   ROM_LIMIT - 1, 8'h33);
      push_beat(OP_DBG_READ,    ROM_LIMIT - 1, 8'h00);
      push_beat(OP_DBG_READ,    16'h0000,      8'h00);
      push_beat(OP_CPU_WRITE,   ROM_LIMIT,     FILL_ONES);
      push_beat(OP_CPU_WRITE,   ADDR_LAST,     8'h00);
      push_beat(OP_DBG_WRITE,   UPPER_RAM,     8'ha5);
      push_beat(OP_CPU_READ,    UPPER_RAM,     8'h00);
      push_beat(OP_SCREEN_READ, 16'h0000,      8'h00);
      push_beat(OP_SCREEN_READ, ROM_LIMIT - 1, 8'h00);
      push_beat(OP_SCREEN_READ, ADDR_LAST,     FILL_ONES);
      push_beat(OP_SPARE,       ADDR_LAST,     FILL_ONES);
      push_beat(OP_CPU_READ,    ADDR_LAST,     8'h00);
      push_beat(OP_ROM_UPLOAD,  16'h0001,      8'h80);

      // Seed the low ROM offsets; a read of a ROM byte that was never uploaded
      // is steered onto one of them.
      for (int n = 1; n < (1 << ROM_SEED_BITS); n++)
         push_beat(OP_ROM_UPLOAD, ADDR_W'(n), DATA_W'($urandom));

      for (int phase = 0; phase < PHASES; phase++) begin
         quiesce();
         set_fill_mode(phase[0]);
         idle_on      = (phase != PHASES - 1);
         useful_beats = 0;
         cleared      = 1'b0;
         squeezed     = (phase[0] != 1'b0);
         clear_at     = $urandom_range(20, PHASE_BEATS - 20);
         while (useful_beats < PHASE_BEATS) begin
            if (!squeezed && useful_beats >= PHASE_BEATS / 2) begin
               squeeze_ask = 1'b1;
               squeezed    = 1'b1;
            end
            if (!cleared && useful_beats >= clear_at) begin
               push_beat(OP_CLEAR, ADDR_W'($urandom), DATA_W'($urandom));
               cleared = 1'b1;
            end else begin
               case ($urandom_range(0, 9))
                  0, 1, 2: begin
                     // upload run, mostly restarted at offset zero
                     a   = ($urandom_range(0, 4) == 0) ? ADDR_W'($urandom_range(0, ROM_BYTES - 1))
                                                       : '0;
                     len = $urandom_range(1, 12);
                     for (int k = 0; k < len; k++)
                        push_beat(OP_ROM_UPLOAD, a + ADDR_W'(k), DATA_W'($urandom));
                  end
                  3, 4, 5: begin
                     // write, then read back by some path; a screen read hits the same byte only inside its window
                     a = pick_address();
                     push_beat($urandom_range(0, 1) ? OP_CPU_WRITE : OP_DBG_WRITE, a,
                               DATA_W'($urandom));
                     case ($urandom_range(0, 2))
                        0:       push_beat(OP_CPU_READ, a, DATA_W'($urandom));
                        1:       push_beat(OP_DBG_READ, a, DATA_W'($urandom));
                        default: push_beat(OP_SCREEN_READ,
                                           {2'($urandom), 14'(a - ROM_LIMIT)},
                                           DATA_W'($urandom));
                     endcase
                  end
                  default: begin
                     op = OPCODE_W'($urandom_range(0, 7));
                     if (op == OP_CLEAR) op = OP_SCREEN_READ;
                     push_beat(op, pick_address(), DATA_W'($urandom));
                  end
               endcase
            end
         end
      end

      quiesce();
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
